// ===== rtl/core/dtr_pkg.sv =====
// Shared types and constants for the two-way ranging calculator.
`timescale 1ns / 1ps
`default_nettype none
package dtr_pkg;
   localparam int DIV_STEPS  = 64;
   localparam int DEN_W      = 34;
   localparam int DELAY_SHIFT = 16;   // 65536 ticks per delay unit
   localparam logic [18:0] MM_PER_TICK_Q16 = 19'd307385;
   localparam logic [15:0] DELAY_RESET = 16'd18000;
   localparam logic [15:0] DIST_MAX = 16'hFFFF;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NEG  = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;
   localparam logic [1:0] ST_DIV0 = 2'd3;

   typedef struct packed {
      logic             valid;
      logic             div0;
      logic             neg;
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem;
      logic [63:0]      work;   // dividend bits out the top, quotient bits in the bottom
      logic [31:0]      send;
   } cell_type;
endpackage
`default_nettype wire

// ===== rtl/core/dtr_div_cell.sv =====
// One restoring-division cell: retires one quotient bit per transaction.
`timescale 1ns / 1ps
`default_nettype none
module dtr_div_cell (
   input  wire               clock,
   input  wire               reset,
   input  wire               en,
   input  dtr_pkg::cell_type cell_in,
   output dtr_pkg::cell_type cell_out
);
   dtr_pkg::cell_type cell_ff, cell_in_c;
   logic [dtr_pkg::DEN_W:0] shifted, trial;

   always_comb begin
      shifted = {cell_in.rem, cell_in.work[63]};
      trial   = shifted - {1'b0, cell_in.den};
      cell_in_c = cell_in;
      cell_in_c.work = {cell_in.work[62:0], ~trial[dtr_pkg::DEN_W]};
      if (!trial[dtr_pkg::DEN_W]) begin
         cell_in_c.rem = trial[dtr_pkg::DEN_W-1:0];
      end else begin
         cell_in_c.rem = shifted[dtr_pkg::DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in_c;
      end
   end

   assign cell_out = cell_ff;
endmodule
`default_nettype wire

// ===== rtl/core/dtr_front.sv =====
// Interval differences, cross products, divisor and send time ahead of the divider.
`timescale 1ns / 1ps
`default_nettype none
module dtr_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               en,
   input  wire               valid_in,
   input  wire  [31:0]       poll_tx,
   input  wire  [31:0]       resp_rx,
   input  wire  [31:0]       final_tx,
   input  wire  [39:0]       poll_rx,
   input  wire  [39:0]       resp_tx,
   input  wire  [39:0]       final_rx,
   input  wire  [15:0]       delay,
   output dtr_pkg::cell_type cell_out
);
   logic        v1_ff, v2_ff;
   logic [31:0] ra_ff, rb_ff, da_ff, db_ff, send1_ff, send2_ff;
   logic [63:0] p_ff, q_ff;
   logic [dtr_pkg::DEN_W-1:0] den_ff;
   logic [39:0] send_sum;
   dtr_pkg::cell_type cell_ff, cell_in;

   assign send_sum = final_rx + {8'd0, delay, {dtr_pkg::DELAY_SHIFT{1'b0}}};

   always_comb begin
      cell_in       = '0;
      cell_in.valid = v2_ff;
      cell_in.div0  = (den_ff == '0);
      cell_in.neg   = (p_ff < q_ff);
      cell_in.den   = den_ff;
      cell_in.work  = cell_in.neg ? (q_ff - p_ff) : (p_ff - q_ff);
      cell_in.send  = send2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff    <= valid_in;
         ra_ff    <= resp_rx - poll_tx;
         rb_ff    <= final_rx[31:0] - resp_tx[31:0];
         da_ff    <= final_tx - resp_rx;
         db_ff    <= resp_tx[31:0] - poll_rx[31:0];
         send1_ff <= send_sum[39:8];
         v2_ff    <= v1_ff;
         p_ff     <= 64'(ra_ff) * 64'(rb_ff);
         q_ff     <= 64'(da_ff) * 64'(db_ff);
         den_ff   <= {2'd0, ra_ff} + {2'd0, rb_ff} + {2'd0, da_ff} + {2'd0, db_ff};
         send2_ff <= send1_ff;
         cell_ff  <= cell_in;
      end
   end

   assign cell_out = cell_ff;
endmodule
`default_nettype wire

// ===== rtl/core/ds_twr_range_calculator_top.sv =====
// Top level of the double-sided two-way ranging calculator.
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Payload
// req_    | in        | tdata: six timestamps (216 bits)
// rsp_    | out       | tdata: distance, send time; tuser: range status
// csr_    | in        | report delay, write enable + data
//
// One transaction per cycle while rsp_ does not stall; the pipeline is three front
// stages, 64 divider cells (one quotient bit each) and the output register,
// with the scaling multiply in front of it. The whole pipeline advances when
// the output register is empty or being taken, so a stall on rsp_ holds every stage.
// Reset clears the valid bits and loads the delay register with 18000.
module ds_twr_range_calculator_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // poll_tx_remote, resp_rx_remote, final_tx_remote, poll_rx_local,
   // resp_tx_local, final_rx_local
   input  wire  [215:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // distance_mm [15:0], report_send_time [47:16]
   output logic [47:0]  rsp_tdata,
   // range_status [1:0]
   output logic [1:0]   rsp_tuser,
   input  wire          csr_we,
   input  wire  [15:0]  csr_wdata
);
   logic        en;
   logic [15:0] delay_ff;
   logic        out_valid_ff;
   logic [15:0] dist_ff, dist_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] send_ff;
   logic [38:0] scaled;

   dtr_pkg::cell_type chain [dtr_pkg::DIV_STEPS+1];

   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= dtr_pkg::DELAY_RESET;
      end else if (csr_we) begin
         delay_ff <= csr_wdata;
      end
   end

   dtr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .valid_in (req_tvalid),
      .poll_tx  (req_tdata[31:0]),
      .resp_rx  (req_tdata[63:32]),
      .final_tx (req_tdata[95:64]),
      .poll_rx  (req_tdata[135:96]),
      .resp_tx  (req_tdata[175:136]),
      .final_rx (req_tdata[215:176]),
      .delay    (delay_ff),
      .cell_out (chain[0])
   );

   // divider: each cell takes one bit of the magnitude, leaves one quotient bit
   for (genvar i = 0; i < dtr_pkg::DIV_STEPS; i++) begin : g_cell
      dtr_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   // quotient below 2^20 here, so a 20 x 19 multiply covers every case left
   assign scaled = 39'(chain[dtr_pkg::DIV_STEPS].work[19:0]) * 39'(dtr_pkg::MM_PER_TICK_Q16);

   always_comb begin
      dist_in   = '0;
      status_in = dtr_pkg::ST_OK;
      if (chain[dtr_pkg::DIV_STEPS].div0) begin
         status_in = dtr_pkg::ST_DIV0;
      end else if (chain[dtr_pkg::DIV_STEPS].neg && (chain[dtr_pkg::DIV_STEPS].work != '0)) begin
         status_in = dtr_pkg::ST_NEG;
      end else if ((chain[dtr_pkg::DIV_STEPS].work[63:20] != '0) || (scaled[38:32] != '0)) begin
         dist_in   = dtr_pkg::DIST_MAX;
         status_in = dtr_pkg::ST_OVF;
      end else begin
         dist_in = scaled[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= chain[dtr_pkg::DIV_STEPS].valid;
         dist_ff      <= dist_in;
         status_ff    <= status_in;
         send_ff      <= chain[dtr_pkg::DIV_STEPS].send;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {send_ff, dist_ff};
   assign rsp_tuser  = status_ff;
endmodule
`default_nettype wire
